FILE: rtl/core/etfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfd_pkg
// Types and constants shared by the telemetry frame decoder and its checker,
// and the CRC-8 byte step used by the decoder.
// ----------------------------------------------------------------------------
package etfd_pkg;

    localparam int unsigned FRAME_BYTES     = 10;
    localparam int unsigned ALT_FRAME_BYTES = 12;
    localparam int unsigned PAYLOAD_BYTES   = 9;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned IDX_W           = $clog2(PAYLOAD_BYTES);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] CRC_IDX   = COUNT_W'(PAYLOAD_BYTES);
    localparam logic [COUNT_W-1:0] LEN_MAIN  = COUNT_W'(FRAME_BYTES);
    localparam logic [COUNT_W-1:0] LEN_ALT   = COUNT_W'(ALT_FRAME_BYTES);

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_LEN = 2'd1,
        STATUS_BAD_CRC = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [7:0]  temperature;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [15:0] consumption;
        logic [15:0] erpm_hundreds;
    } t_out_word;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/esc_telemetry_frame_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_telemetry_frame_decoder_unit
// Decodes ESC telemetry frames: byte count, CRC-8 check and field extraction.
// ----------------------------------------------------------------------------
// Takes one received byte per clock unless stalled. Each word passes an input
// register and is folded into the frame state (one CRC-8 byte step); the word
// carrying frame_end loads the result register from the input register once
// the result register is free. The input side stalls only while the result
// register is full and stalled; otherwise one word is accepted every cycle.
module esc_telemetry_frame_decoder_unit
    import etfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  wire        i_out_stall
);

    logic               r_in_valid;
    t_in_word           r_in_word;
    logic               r_out_valid;
    t_out_word          r_out_word;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_crc, n_crc;
    logic               r_match, n_match;
    logic [7:0]         r_store [PAYLOAD_BYTES];
    logic               out_free;
    logic               advance;
    logic               in_take;
    t_out_word          n_out_word;
    logic [COUNT_W-1:0] len;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_crc   = r_crc;
        n_match = r_match;
        n_count = r_count;
        if (r_count < CRC_IDX) begin
            n_crc = crc_step(r_crc, r_in_word.rx_byte);
        end else if (r_count == CRC_IDX) begin
            n_match = (r_crc == r_in_word.rx_byte);
        end
        if (r_count < COUNT_MAX) begin
            n_count = r_count + COUNT_W'(1);
        end
        len = n_count;

        n_out_word = '0;
        if (len != LEN_MAIN && len != LEN_ALT) begin
            n_out_word.status = STATUS_BAD_LEN;
        end else if (!n_match) begin
            n_out_word.status = STATUS_BAD_CRC;
        end else begin
            n_out_word.status        = STATUS_OK;
            n_out_word.temperature   = r_store[0];
            n_out_word.voltage       = {r_store[1], r_store[2]};
            n_out_word.current       = {r_store[3], r_store[4]};
            n_out_word.consumption   = {r_store[5], r_store[6]};
            n_out_word.erpm_hundreds = {r_store[7], r_store[8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_crc       <= '0;
            r_match     <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
            if (out_free) begin
                r_out_valid <= advance && r_in_word.frame_end;
            end
            if (advance) begin
                if (r_in_word.frame_end) begin
                    r_count <= '0;
                    r_crc   <= '0;
                    r_match <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_crc   <= n_crc;
                    r_match <= n_match;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance && r_count < CRC_IDX) begin
            r_store[r_count[IDX_W-1:0]] <= r_in_word.rx_byte;
        end
        if (advance && r_in_word.frame_end) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/etfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etfd_checker
// Port-level assertions for the telemetry frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module etfd_checker
    import etfd_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input t_in_word  i_in_word,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input t_out_word o_out_word,
    input wire       i_out_stall
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != STATUS_OK |->
            o_out_word.temperature == 8'd0 && o_out_word.voltage == 16'd0 &&
            o_out_word.current == 16'd0 && o_out_word.consumption == 16'd0 &&
            o_out_word.erpm_hundreds == 16'd0)
        else $error("bad frame carries nonzero fields");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind esc_telemetry_frame_decoder_unit etfd_checker u_etfd_checker (.*);
`default_nettype wire

FILE: dv/tb_esc_telemetry_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_esc_telemetry_frame_decoder_unit
// Streams telemetry frames through the decoder and checks each result.
// ----------------------------------------------------------------------------
// The stimulus is mostly 10- and 12-byte frames with good or corrupted CRC
// bytes. The rest is frames of random length and loose bytes. A local frame
// tracker folds in every accepted word and queues the expected result. Both
// sides idle in random bursts. The receiver also holds off for a long stretch
// twice, and the sender once drains all pending results before the next frame.
// ----------------------------------------------------------------------------
module tb_esc_telemetry_frame_decoder_unit;
    import etfd_pkg::*;

    typedef struct {
        t_in_word word;
        bit       wait_drain;
    } t_pending_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    t_pending_word rx_word_q[$];
    t_out_word     telemetry_q[$];

    logic [COUNT_W-1:0] trk_count = '0;
    logic [7:0]         trk_crc   = '0;
    logic [7:0]         trk_bytes [PAYLOAD_BYTES];
    logic               trk_crc_ok = 1'b0;

    int unsigned   fail_count = 0;
    int unsigned   cyc        = 0;
    int unsigned   tx_gap     = 0;
    int unsigned   rx_hold    = 0;
    int unsigned   rx_seen    = 0;
    int unsigned   long_at    = 25;
    t_pending_word tx_next;
    t_out_word     rx_want;

    esc_telemetry_frame_decoder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    task automatic fold_byte(input t_in_word w);
        t_out_word r;
        r = '0;
        if (trk_count < CRC_IDX) begin
            trk_bytes[trk_count] = w.rx_byte;
            trk_crc = crc8_next(trk_crc, w.rx_byte);
        end else if (trk_count == CRC_IDX) begin
            trk_crc_ok = (trk_crc == w.rx_byte);
        end
        if (trk_count != COUNT_MAX) begin
            trk_count = trk_count + COUNT_W'(1);
        end
        if (w.frame_end) begin
            if (trk_count != LEN_MAIN && trk_count != LEN_ALT) begin
                r.status = STATUS_BAD_LEN;
            end else if (!trk_crc_ok) begin
                r.status = STATUS_BAD_CRC;
            end else begin
                r.status        = STATUS_OK;
                r.temperature   = trk_bytes[0];
                r.voltage       = {trk_bytes[1], trk_bytes[2]};
                r.current       = {trk_bytes[3], trk_bytes[4]};
                r.consumption   = {trk_bytes[5], trk_bytes[6]};
                r.erpm_hundreds = {trk_bytes[7], trk_bytes[8]};
            end
            telemetry_q.push_back(r);
            trk_count  = '0;
            trk_crc    = '0;
            trk_crc_ok = 1'b0;
        end
    endtask

    // fill < 0 gives random bytes
    task automatic queue_frame(input int unsigned len, input bit crc_good,
                               input bit wait_drain, input int fill);
        logic [7:0]    acc;
        t_pending_word p;
        acc = '0;
        for (int unsigned i = 0; i < len; i++) begin
            p.word.rx_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i < PAYLOAD_BYTES) begin
                acc = crc8_next(acc, p.word.rx_byte);
            end else if (i == PAYLOAD_BYTES) begin
                p.word.rx_byte = crc_good ? acc : acc ^ 8'($urandom_range(1, 255));
            end
            p.word.frame_end = (i == len - 1);
            p.wait_drain     = wait_drain && (i == 0);
            rx_word_q.push_back(p);
        end
    endtask

    // driver: advance only on accept, hold while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                fold_byte(i_in_word);
            end
            if (i_in_valid && o_in_stall) begin
            end else if (tx_gap != 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (rx_word_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (rx_word_q[0].wait_drain && telemetry_q.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (rx_word_q.size() > 150 && cyc[9:8] != 2'd0
                         && $urandom_range(0, 2 + 3 * cyc[9:8]) == 0) begin
                tx_gap = $urandom_range(1, 12) - 1;
                i_in_valid <= 1'b0;
            end else begin
                tx_next = rx_word_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_word  <= tx_next.word;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                rx_seen++;
                if (telemetry_q.size() == 0) begin
                    $error("result with no frame pending");
                    fail_count++;
                end else begin
                    rx_want = telemetry_q.pop_front();
                    if (o_out_word.status !== rx_want.status) begin
                        $error("status: expected %0d, got %0d",
                               rx_want.status, o_out_word.status);
                        fail_count++;
                    end
                    if (o_out_word.temperature !== rx_want.temperature) begin
                        $error("temperature: expected %0d, got %0d",
                               rx_want.temperature, o_out_word.temperature);
                        fail_count++;
                    end
                    if (o_out_word.voltage !== rx_want.voltage) begin
                        $error("voltage: expected %0d, got %0d",
                               rx_want.voltage, o_out_word.voltage);
                        fail_count++;
                    end
                    if (o_out_word.current !== rx_want.current) begin
                        $error("current: expected %0d, got %0d",
                               rx_want.current, o_out_word.current);
                        fail_count++;
                    end
                    if (o_out_word.consumption !== rx_want.consumption) begin
                        $error("consumption: expected %0d, got %0d",
                               rx_want.consumption, o_out_word.consumption);
                        fail_count++;
                    end
                    if (o_out_word.erpm_hundreds !== rx_want.erpm_hundreds) begin
                        $error("erpm_hundreds: expected %0d, got %0d",
                               rx_want.erpm_hundreds, o_out_word.erpm_hundreds);
                        fail_count++;
                    end
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (long_at != 0 && rx_seen >= long_at) begin
                rx_hold = 399;
                long_at = (long_at == 25) ? 90 : 0;
                i_out_stall <= 1'b1;
            end else if (rx_word_q.size() > 150 && cyc[10:9] != 2'd0
                         && $urandom_range(0, 2 + 3 * cyc[10:9]) == 0) begin
                rx_hold = $urandom_range(1, 12) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned sel;
        bit          drained;
        drained = 1'b0;
        queue_frame(1, 1'b1, 1'b0, 0);
        queue_frame(10, 1'b1, 1'b0, 255);
        queue_frame(12, 1'b0, 1'b0, -1);
        while (rx_word_q.size() < 1850) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                queue_frame($urandom_range(0, 1) ? 10 : 12, $urandom_range(0, 9) != 0,
                            !drained && rx_word_q.size() > 900, -1);
                if (rx_word_q.size() > 900) begin
                    drained = 1'b1;
                end
            end else if (sel < 90) begin
                queue_frame($urandom_range(1, 20), $urandom_range(0, 1), 1'b0, -1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    tx_next.word.rx_byte   = 8'($urandom);
                    tx_next.word.frame_end = ($urandom_range(0, 5) == 0);
                    tx_next.wait_drain     = 1'b0;
                    rx_word_q.push_back(tx_next);
                end
            end
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (rx_word_q.size() != 0 || i_in_valid || telemetry_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_esc_telemetry_frame_decoder_unit OK");
        end else begin
            $display("tb_esc_telemetry_frame_decoder_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_esc_telemetry_frame_decoder_unit NOT OK");
        $finish;
    end

endmodule

FILE: esc_telemetry_frame_decoder_unit.f
rtl/core/etfd_pkg.sv
rtl/core/esc_telemetry_frame_decoder_unit.sv
rtl/core/etfd_checker.sv
dv/tb_esc_telemetry_frame_decoder_unit.sv
